### src/wsc_pkg.sv
// shared types and constants of the wavetable sound channel
package wsc_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_AW    = $clog2(WAVE_BYTES);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CTRL  = 2'd1,
        OP_WAVE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        REG_ENABLE  = 4'd0,
        REG_LENGTH  = 4'd1,
        REG_VOLUME  = 4'd2,
        REG_FREQ_LO = 4'd3,
        REG_FREQ_HI = 4'd4
    } ctrl_reg_t;

    localparam logic [13:0] TIMER_RESET = 14'd4096;
    localparam logic [11:0] PERIOD_BASE = 12'd2048;

endpackage

### src/wavetable_sound_channel.sv
// wavetable sound channel top level: control state, wave ram and result pipeline
//
// Wave sound channel that plays 32 four-bit samples stored in a 16-byte wave
// ram. Every input item is a timer tick of tick_count, a control register
// write, a wave ram byte write or no operation, and produces exactly one
// result item with the sample, the on flag and the play position as they
// stand after that item. The block takes one item per clock cycle while the
// output is not stalled; a result passes through the synchronous wave ram
// read stage and then the output register. The scalar state (timer, period,
// volume, position, on flag) is updated in the accept cycle, so back-to-back
// items see each other at once. A wave ram write and a read of the same byte
// in the same cycle are forwarded. The wave ram reads as zero after reset
// through a per-byte written flag, so no clearing pass is needed and items
// are taken straight after reset.
module wavetable_sound_channel
    import wsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [3:0] reg_index,
    input  logic [7:0] write_data,
    input  logic [5:0] tick_count,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] sample,
    output logic       channel_on,
    output logic [4:0] wave_position
);

    // wave ram and per-byte written flags
    logic [7:0]            wave_mem [WAVE_BYTES];
    logic [WAVE_BYTES-1:0] wave_vld_reg;

    // channel state
    logic        on_reg,     on_next;
    logic [1:0]  vol_reg,    vol_next;
    logic [10:0] period_reg, period_next;
    logic [13:0] timer_reg,  timer_next;
    logic [4:0]  pos_reg,    pos_next;

    // read stage
    logic        s1_valid_reg;
    logic        s1_on_reg;
    logic [1:0]  s1_vol_reg;
    logic [4:0]  s1_pos_reg;
    logic [7:0]  rd_data_reg;
    logic        rd_vld_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_data_reg;

    // output register
    logic        out_valid_reg;
    logic [3:0]  sample_reg;
    logic        on_out_reg;
    logic [4:0]  pos_out_reg;

    logic        accept;
    logic        out_load;
    logic        s1_adv;
    op_t         op;
    logic        wave_wr;
    logic [WAVE_AW-1:0] wr_addr;
    logic [WAVE_AW-1:0] rd_addr;
    logic [12:0] reload;
    logic [14:0] diff;
    logic [14:0] wrapped;
    logic [7:0]  s1_byte;
    logic [3:0]  s1_nib;
    logic [3:0]  s1_sample;

    // handshake: output register frees when empty or taken, read stage follows
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;

    assign op      = op_t'(operation);
    assign wave_wr = accept && (op == OP_WAVE);
    assign wr_addr = reg_index[WAVE_AW-1:0];

    // next channel state for the accepted item
    always_comb
    begin
        on_next     = on_reg;
        vol_next    = vol_reg;
        period_next = period_reg;
        timer_next  = timer_reg;
        pos_next    = pos_reg;
        reload      = 13'd0;
        diff        = 15'd0;
        wrapped     = 15'd0;
        case (op)
            OP_TICK:
            begin
                // signed 15-bit timer arithmetic; a deficit past the reload
                // value saturates at zero
                diff   = {1'b0, timer_reg} - {9'd0, tick_count};
                reload = {(PERIOD_BASE - {1'b0, period_reg}), 1'b0};
                if (diff[14])
                begin
                    wrapped    = diff + {2'b00, reload};
                    timer_next = wrapped[14] ? 14'd0 : wrapped[13:0];
                    pos_next   = pos_reg + 5'd1;
                end
                else
                begin
                    timer_next = diff[13:0];
                end
            end
            OP_CTRL:
            begin
                case (ctrl_reg_t'(reg_index))
                    REG_ENABLE:  on_next = write_data[7];
                    REG_LENGTH:  on_next = 1'b1;
                    REG_VOLUME:  vol_next = write_data[6:5];
                    REG_FREQ_LO: period_next = {period_reg[10:8], write_data};
                    REG_FREQ_HI:
                    begin
                        period_next = {write_data[2:0], period_reg[7:0]};
                        if (write_data[7])
                        begin
                            // trigger reloads from the period just written
                            reload     = {(PERIOD_BASE - {1'b0, period_next}), 1'b0};
                            on_next    = 1'b1;
                            timer_next = {1'b0, reload};
                            pos_next   = 5'd0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // sample byte comes from the position after this item
    assign rd_addr = pos_next[4:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg        <= 1'b0;
            vol_reg       <= 2'd0;
            period_reg    <= 11'd0;
            timer_reg     <= TIMER_RESET;
            pos_reg       <= 5'd0;
            wave_vld_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                on_reg     <= on_next;
                vol_reg    <= vol_next;
                period_reg <= period_next;
                timer_reg  <= timer_next;
                pos_reg    <= pos_next;
            end
            if (wave_wr)
                wave_vld_reg[wr_addr] <= 1'b1;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // wave ram write port
    always_ff @(posedge clk)
    begin
        if (wave_wr)
            wave_mem[wr_addr] <= write_data;
    end

    // wave ram read port and read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg  <= wave_mem[rd_addr];
            rd_vld_reg   <= wave_vld_reg[rd_addr];
            fwd_reg      <= wave_wr && (wr_addr == rd_addr);
            fwd_data_reg <= write_data;
            s1_on_reg    <= on_next;
            s1_vol_reg   <= vol_next;
            s1_pos_reg   <= pos_next;
        end
    end

    // nibble select and volume shift
    always_comb
    begin
        if (fwd_reg)
            s1_byte = fwd_data_reg;
        else if (rd_vld_reg)
            s1_byte = rd_data_reg;
        else
            s1_byte = 8'd0;
        s1_nib = s1_pos_reg[0] ? s1_byte[3:0] : s1_byte[7:4];
        if (!s1_on_reg || (s1_vol_reg == 2'd0))
            s1_sample = 4'd0;
        else
            s1_sample = s1_nib >> (s1_vol_reg - 2'd1);
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            sample_reg  <= s1_sample;
            on_out_reg  <= s1_on_reg;
            pos_out_reg <= s1_pos_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign channel_on    = on_out_reg;
    assign wave_position = pos_out_reg;

    // a result of a channel that is off carries a silent sample
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !channel_on |-> sample == 4'd0)
        else $error("sample not silent while channel off");

    // a trigger write restarts the channel at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_CTRL) && (reg_index == REG_FREQ_HI) && write_data[7]
        |=> on_reg && (pos_reg == 5'd0))
        else $error("trigger did not restart the channel");

    // a full pipeline with a stalled output holds off new items
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid && out_stall |-> in_stall)
        else $error("item accepted into a full pipeline");

    // the timer never exceeds its largest reload value
    assert property (@(posedge clk) disable iff (!rst_n)
        timer_reg <= TIMER_RESET)
        else $error("frequency timer out of range");

endmodule
